// File: design/pal_pkg.sv
package pal_pkg;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FPOS_W = 7;
  localparam int unsigned CNT_W  = 8;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

// File: design/pal_ram.sv
module pal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/positional_array_list.sv
// Positional array list: an ordered list of signed 32-bit values kept in a
// single-port-read, single-port-write RAM of CAPACITY entries plus a count.
// Each transaction on the slave stream is one request: insert a value at a
// position, delete the entry at a position, or search for the lowest
// position that holds a value. Every request yields exactly one transaction
// on the master stream carrying status, found position and the new count.
// Requests are processed one at a time; s_axis_tready is high only while
// the sequencer is idle. An insert at a position p below the count shifts
// the entries from the last one down to p up by one and then writes the
// value; an append writes it at once. A delete at p shifts the entries
// above p down by one, and a delete of the last entry only lowers the
// count. A search reads from position 0 until a match or the end; an
// empty-list search or a rejected or unused request goes straight to the
// result. The next request can be accepted in the cycle the result appears.
// Each moved or compared entry is read once through the one registered RAM
// read port, and each moved entry is written once through the one write port.
// The result sits in an output register; the next request is accepted
// while it waits, and the sequencer holds a finished result until the
// output register is free when the receiver stalls. Reset empties the list
// and drops any pending result; RAM contents are kept, as only entries
// below the count are ever read.
module positional_array_list
  import pal_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // Fields from bit 0: position[7:0], value[39:8].
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // Fields from bit 0: req_type[1:0].
  input  logic [REQ_W-1:0]     s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // Fields from bit 0: found_position[6:0], count[14:7], zero pad[15].
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // Fields from bit 0: status[0].
  output logic                 m_axis_tuser_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SHIFT_UP  = 3'd1;
  localparam logic [2:0] ST_WRITE_VAL = 3'd2;
  localparam logic [2:0] ST_SHIFT_DN  = 3'd3;
  localparam logic [2:0] ST_SEARCH    = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              rd_pend_q, rd_pend_d;
  logic              issue_q, issue_d;
  logic              m_valid_q, m_valid_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     last_q, last_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic              res_status_q, res_status_d;
  logic [FPOS_W-1:0] res_fpos_q, res_fpos_d;
  logic              out_status_q, out_status_d;
  logic [FPOS_W-1:0] out_fpos_q, out_fpos_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [VAL_W-1:0]  ram_rdata;

  logic              s_fire;
  logic [CMPW-1:0]   pos_ext;
  logic [CMPW-1:0]   cnt_ext;
  logic [AW-1:0]     pos_in;
  logic [AW-1:0]     cnt_m1;
  logic              out_free;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign pos_ext  = CMPW'(s_axis_tdata_i[POS_W-1:0]);
  assign cnt_ext  = CMPW'(count_q);
  assign pos_in   = AW'(s_axis_tdata_i[POS_W-1:0]);
  assign cnt_m1   = AW'(count_q - 1'b1);
  assign out_free = !m_valid_q || m_axis_tready_i;

  pal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_pend_d    = 1'b0;
    issue_d      = issue_q;
    m_valid_d    = m_valid_q;
    ptr_d        = ptr_q;
    rd_addr_d    = ptr_q;
    pos_d        = pos_q;
    last_d       = last_q;
    value_d      = value_q;
    res_status_d = res_status_q;
    res_fpos_d   = res_fpos_q;
    out_status_d = out_status_q;
    out_fpos_d   = out_fpos_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wdata    = value_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          value_d      = s_axis_tdata_i[POS_W +: VAL_W];
          pos_d        = pos_in;
          res_status_d = STATUS_FAIL;
          res_fpos_d   = '0;
          state_d      = ST_DONE;
          case (s_axis_tuser_i)
            REQ_INSERT: begin
              if (pos_ext <= cnt_ext && count_q < CW'(CAPACITY)) begin
                res_status_d = STATUS_OK;
                if (pos_ext == cnt_ext) begin
                  state_d = ST_WRITE_VAL;
                end else begin
                  ptr_d   = cnt_m1;
                  issue_d = 1'b1;
                  state_d = ST_SHIFT_UP;
                end
              end
            end
            REQ_DELETE: begin
              if (pos_ext < cnt_ext) begin
                res_status_d = STATUS_OK;
                last_d       = cnt_m1;
                if (pos_in == cnt_m1) begin
                  count_d = count_q - 1'b1;
                end else begin
                  ptr_d   = AW'(pos_in + 1'b1);
                  issue_d = 1'b1;
                  state_d = ST_SHIFT_DN;
                end
              end
            end
            REQ_SEARCH: begin
              if (count_q != '0) begin
                last_d  = cnt_m1;
                ptr_d   = '0;
                issue_d = 1'b1;
                state_d = ST_SEARCH;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SHIFT_UP: begin
        if (rd_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(rd_addr_q + 1'b1);
          ram_wdata = ram_rdata;
        end
        rd_pend_d = issue_q;
        if (issue_q) begin
          ptr_d = AW'(ptr_q - 1'b1);
          if (ptr_q == pos_q) begin
            issue_d = 1'b0;
          end
        end else begin
          state_d = ST_WRITE_VAL;
        end
      end

      ST_WRITE_VAL: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = value_q;
        count_d   = count_q + 1'b1;
        state_d   = ST_DONE;
      end

      ST_SHIFT_DN: begin
        if (rd_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(rd_addr_q - 1'b1);
          ram_wdata = ram_rdata;
        end
        rd_pend_d = issue_q;
        if (issue_q) begin
          ptr_d = AW'(ptr_q + 1'b1);
          if (ptr_q == last_q) begin
            issue_d = 1'b0;
          end
        end else begin
          count_d = count_q - 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_SEARCH: begin
        if (rd_pend_q && ram_rdata == value_q) begin
          res_status_d = STATUS_OK;
          res_fpos_d   = FPOS_W'(rd_addr_q);
          issue_d      = 1'b0;
          state_d      = ST_DONE;
        end else if (!issue_q && !rd_pend_q) begin
          state_d = ST_DONE;
        end else begin
          rd_pend_d = issue_q;
          if (issue_q) begin
            ptr_d = AW'(ptr_q + 1'b1);
            if (ptr_q == last_q) begin
              issue_d = 1'b0;
            end
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          m_valid_d    = 1'b1;
          out_status_d = res_status_q;
          out_fpos_d   = res_fpos_q;
          out_count_d  = CNT_W'(count_q);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_pend_q <= 1'b0;
      issue_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_pend_q <= rd_pend_d;
      issue_q   <= issue_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    rd_addr_q    <= rd_addr_d;
    pos_q        <= pos_d;
    last_q       <= last_d;
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_fpos_q   <= res_fpos_d;
    out_status_q <= out_status_d;
    out_fpos_q   <= out_fpos_d;
    out_count_q  <= out_count_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_count_q, out_fpos_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

// File: dv/positional_array_list_checker.sv
module positional_array_list_checker
  import pal_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic [REQ_W-1:0]     s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  input  logic                 m_tuser_i,
  output logic [31:0]          fail_cnt_o,
  output logic [31:0]          pending_o,
  output logic [31:0]          list_len_o
);

  typedef struct packed {
    logic              status;
    logic [FPOS_W-1:0] fpos;
    logic [CNT_W-1:0]  cnt;
  } list_reply_t;

  logic [VAL_W-1:0] store [CAPACITY];
  int               list_len;
  list_reply_t      reply_q [$];

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
    list_len_o = 0;
    list_len   = 0;
  end

  // Applies one request to the shadow list and returns the reply it should produce.
  function automatic list_reply_t apply_request(input logic [REQ_W-1:0] kind,
                                                input logic [POS_W-1:0] pos,
                                                input logic [VAL_W-1:0] val);
    list_reply_t r;
    int          i;
    bit          hit;
    r.status = STATUS_FAIL;
    r.fpos   = '0;
    hit      = 1'b0;
    case (kind)
      REQ_INSERT: begin
        if (int'(pos) <= list_len && list_len < CAPACITY) begin
          for (i = list_len; i > int'(pos); i--) store[i] = store[i-1];
          store[pos] = val;
          list_len++;
          r.status = STATUS_OK;
        end
      end
      REQ_DELETE: begin
        if (int'(pos) < list_len) begin
          for (i = int'(pos); i + 1 < list_len; i++) store[i] = store[i+1];
          list_len--;
          r.status = STATUS_OK;
        end
      end
      REQ_SEARCH: begin
        for (i = 0; i < list_len && !hit; i++) begin
          if (store[i] == val) begin
            hit      = 1'b1;
            r.status = STATUS_OK;
            r.fpos   = i[FPOS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    r.cnt = list_len[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_reply(input list_reply_t got);
    list_reply_t exp;
    if (reply_q.size() == 0) begin
      fail_cnt_o = fail_cnt_o + 1;
      if (fail_cnt_o <= 10)
        $display("unexpected reply: status %0d pos %0d count %0d",
                 got.status, got.fpos, got.cnt);
    end else begin
      exp = reply_q.pop_front();
      if (got.status !== exp.status || got.fpos !== exp.fpos || got.cnt !== exp.cnt) begin
        fail_cnt_o = fail_cnt_o + 1;
        if (fail_cnt_o <= 10)
          $display("reply mismatch: expected status %0d pos %0d count %0d, got status %0d pos %0d count %0d",
                   exp.status, exp.fpos, exp.cnt, got.status, got.fpos, got.cnt);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_q.delete();
      list_len   = 0;
      pending_o  = 0;
      list_len_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i)
        check_reply({m_tuser_i, m_tdata_i[FPOS_W-1:0], m_tdata_i[FPOS_W+CNT_W-1:FPOS_W]});
      if (s_tvalid_i && s_tready_i)
        reply_q.push_back(apply_request(s_tuser_i, s_tdata_i[POS_W-1:0],
                                        s_tdata_i[POS_W+VAL_W-1:POS_W]));
      pending_o  = reply_q.size();
      list_len_o = list_len;
    end
  end

endmodule

// File: dv/positional_array_list_tb.sv
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int unsigned CAPACITY    = 128;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 4000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  // Fields from bit 0: position[7:0], value[39:8].
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  // Fields from bit 0: req_type[1:0].
  logic [REQ_W-1:0]     s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  // Fields from bit 0: found_position[6:0], count[14:7], zero pad[15].
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  // Fields from bit 0: status[0].
  logic                 m_axis_tuser_o;

  logic [31:0] fail_cnt;
  logic [31:0] pending;
  logic [31:0] list_len;

  int          idle_pct;
  int          stall_pct;
  bit          hold_req;
  int unsigned quiet_cycles;
  logic [VAL_W-1:0] pool [16];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  positional_array_list #(.CAPACITY(CAPACITY)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  positional_array_list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_i (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_i (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_i  (m_axis_tdata_o),
    .m_tuser_i  (m_axis_tuser_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .list_len_o (list_len)
  );

  // The receiver stalls at random, or holds off for a long stretch on request.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99, 0) >= stall_pct);
        @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("positional_array_list_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(9, 0) < 7) return pool[$urandom_range(15, 0)];
    return $urandom;
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val);
    while ($urandom_range(99, 0) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {val, pos};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic send_mixed(input int n);
    int               k;
    int               pick;
    int               ins_w;
    int               len;
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    ins_w = 40;
    for (k = 0; k < n; k++) begin
      if (k % 25 == 0) ins_w = $urandom_range(60, 20);
      len  = list_len;
      pick = $urandom_range(99, 0);
      if (pick < ins_w) begin
        kind = REQ_INSERT;
        pos  = POS_W'($urandom_range(len, 0));
      end else if (pick < 80) begin
        kind = REQ_DELETE;
        pos  = (len == 0) ? '0 : POS_W'($urandom_range(len - 1, 0));
      end else if (pick < 97) begin
        kind = REQ_SEARCH;
        pos  = POS_W'($urandom_range(255, 0));
      end else begin
        kind = REQ_UNUSED;
        pos  = POS_W'($urandom_range(255, 0));
      end
      if ($urandom_range(9, 0) == 0) pos = POS_W'($urandom_range(255, 0));
      send_req(kind, pos, pick_value());
    end
  endtask

  initial begin
    int k;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_INSERT;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_req        = 1'b0;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (k = 4; k < 16; k++) pool[k] = $urandom;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Edge cases on an empty list, then a small list with duplicates and extremes.
    send_req(REQ_SEARCH, 8'd0,   32'h0000_0000);
    send_req(REQ_DELETE, 8'd0,   32'h0000_0000);
    send_req(REQ_INSERT, 8'd1,   32'h1234_5678);
    send_req(REQ_INSERT, 8'd255, 32'hffff_ffff);
    send_req(REQ_INSERT, 8'd0,   32'h8000_0000);
    send_req(REQ_INSERT, 8'd1,   32'h7fff_ffff);
    send_req(REQ_INSERT, 8'd0,   32'h0000_0000);
    send_req(REQ_INSERT, 8'd3,   32'hffff_ffff);
    send_req(REQ_INSERT, 8'd2,   32'h0000_0000);
    send_req(REQ_SEARCH, 8'd0,   32'h0000_0000);
    send_req(REQ_SEARCH, 8'd0,   32'h7fff_ffff);
    send_req(REQ_SEARCH, 8'd17,  32'hffff_ffff);
    send_req(REQ_SEARCH, 8'd255, 32'h8000_0000);
    send_req(REQ_SEARCH, 8'd0,   32'h0000_0005);
    send_req(REQ_UNUSED, 8'd0,   32'h0000_0000);
    send_req(REQ_UNUSED, 8'd255, 32'hffff_ffff);
    send_req(REQ_DELETE, 8'd5,   32'h0000_0000);
    send_req(REQ_DELETE, 8'd255, 32'h0000_0000);
    send_req(REQ_DELETE, 8'd4,   32'h0000_0000);
    send_req(REQ_DELETE, 8'd0,   32'h0000_0000);
    send_req(REQ_DELETE, 8'd1,   32'h0000_0000);
    send_req(REQ_INSERT, 8'd2,   32'h5555_aaaa);

    // Start a long receiver hold-off, then fill the list to capacity and probe the full list.
    hold_req = 1'b1;
    while (list_len < CAPACITY)
      send_req(REQ_INSERT, POS_W'($urandom_range(list_len, 0)), pick_value());
    repeat (4) send_req(REQ_INSERT, POS_W'($urandom_range(255, 0)), pick_value());
    repeat (6) send_req(REQ_SEARCH, POS_W'($urandom_range(255, 0)), pick_value());
    send_mixed(100);

    idle_pct  = 81;
    stall_pct = 0;
    send_mixed(100);
    idle_pct  = 0;
    stall_pct = 81;
    send_mixed(100);
    idle_pct  = 28;
    stall_pct = 28;
    send_mixed(100);

    s_axis_tvalid_i <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (CAPACITY + 10) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0)
      $display("positional_array_list_tb OK");
    else
      $display("positional_array_list_tb NOT OK");
    $finish;
  end

endmodule
